[src/ece_pkg.sv]
// shared types, constants, tables and arithmetic helpers for the easing curve evaluator
package ece_pkg;

   localparam int FRAC_BITS       = 15;
   localparam int TABLE_ADDR_BITS = 8;
   localparam int IBITS           = 30;
   localparam int TAB_N           = 1 << TABLE_ADDR_BITS;
   localparam int TIME_W          = 16;
   localparam int Q_W             = 36;

   localparam logic [15:0] T_ONE  = 16'(1 << FRAC_BITS);
   localparam logic [15:0] T_HALF = 16'(1 << (FRAC_BITS - 1));
   localparam logic [30:0] I_ONE  = 31'(1 << IBITS);

   localparam longint unsigned PIO2_Q30 = 64'd1686629713;
   localparam longint unsigned LN2_Q30  = 64'd744261118;

   localparam logic [2:0] KIND_LINEAR = 3'd0;
   localparam logic [2:0] KIND_QUAD   = 3'd1;
   localparam logic [2:0] KIND_QUINT  = 3'd4;
   localparam logic [2:0] KIND_SINE   = 3'd5;
   localparam logic [2:0] KIND_EXPO   = 3'd6;

   localparam logic [1:0] DIR_IN    = 2'd0;
   localparam logic [1:0] DIR_OUT   = 2'd1;
   localparam logic [1:0] DIR_INOUT = 2'd2;
   localparam logic [1:0] DIR_SPARE = 2'd3;

   localparam logic REG_CURVE_KIND = 1'b0;
   localparam logic REG_EASE_DIR   = 1'b1;

   typedef logic [30:0] tab_type [0:TAB_N];

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  dir;
      logic        lo;
      logic        t_zero;
      logic        t_one;
      logic [15:0] ts;
      logic [15:0] x;
      logic [30:0] p;
      logic [2:0]  steps;
      logic [8:0]  idx;
      logic [14:0] frac;
      logic [3:0]  k;
      logic [30:0] a;
      logic [30:0] b;
      logic        up;
      logic [45:0] prod;
      logic [30:0] lk;
   } stage_type;

   // truncating long division, only used while the tables are built at elaboration
   function automatic longint unsigned cdiv(longint unsigned num, longint unsigned den);
      longint unsigned quo, rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // quarter-wave sine, Q30 taylor series up to x^15
   function automatic tab_type build_sin();
      tab_type        tab;
      longint unsigned x, x2, term, sum;
      for (int i = 0; i <= TAB_N; i++) begin
         x    = (longint'(i) * PIO2_Q30 + longint'(TAB_N >> 1)) >> TABLE_ADDR_BITS;
         x2   = (x * x) >> IBITS;
         term = x;
         sum  = x;
         for (int k = 1; k <= 7; k++) begin
            term = cdiv((term * x2) >> IBITS, longint'((2 * k) * (2 * k + 1)));
            if ((k & 1) != 0) sum = (sum > term) ? sum - term : 64'd0;
            else sum = sum + term;
         end
         if (sum > longint'(I_ONE)) sum = longint'(I_ONE);
         if (i == 0) sum = 64'd0;
         if (i == TAB_N) sum = longint'(I_ONE);
         if (i > 0 && sum < longint'(tab[i-1])) sum = longint'(tab[i-1]);
         tab[i] = sum[30:0];
      end
      return tab;
   endfunction

   // e^-z over one octave, Q30 series up to z^12
   function automatic tab_type build_exp();
      tab_type        tab;
      longint unsigned z, term, sum;
      for (int i = 0; i <= TAB_N; i++) begin
         z    = (longint'(i) * LN2_Q30 + longint'(TAB_N >> 1)) >> TABLE_ADDR_BITS;
         term = longint'(I_ONE);
         sum  = longint'(I_ONE);
         for (int k = 1; k <= 12; k++) begin
            term = cdiv((term * z) >> IBITS, longint'(k));
            if ((k & 1) != 0) sum = (sum > term) ? sum - term : 64'd0;
            else sum = sum + term;
         end
         if (sum > longint'(I_ONE)) sum = longint'(I_ONE);
         if (i == 0) sum = longint'(I_ONE);
         if (i == TAB_N) sum = longint'(I_ONE >> 1);
         if (i > 0 && sum > longint'(tab[i-1])) sum = longint'(tab[i-1]);
         tab[i] = sum[30:0];
      end
      return tab;
   endfunction

   localparam tab_type SIN_TAB = build_sin();
   localparam tab_type EXP_TAB = build_exp();

   // one power step: round(p * x / 2^15)
   function automatic logic [30:0] pow_step(logic [30:0] p, logic [15:0] x);
      logic [46:0] tmp;
      tmp = 47'(p) * 47'(x) + 47'(T_HALF);
      return tmp[45:15];
   endfunction

   function automatic logic [Q_W-1:0] sub0(logic [Q_W-1:0] a, logic [Q_W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

endpackage

[src/easing_curve_evaluator_top.sv]
// top level of the easing curve evaluator: config registers and six-stage datapath
//
//  channel | direction | fields
//  req_    | in        | tdata[15:0] time_in, unsigned Q1.15
//  rsp_    | out       | tdata[15:0] eased_value, unsigned Q1.15
//  csr_    | in/out    | 0x0 curve_kind[2:0], 0x4 ease_direction[1:0]
//
// six register stages, one transaction per clock sustained while rsp_ is not stalled
// stage 1 folds direction, stages 2-5 hold the table read, interpolation multiply,
// the power multiply chain (one 31x16 multiply per stage) and the exponent shift
// stage 6 combines and rounds into the output register
// a stall on rsp_ freezes every stage together; nothing is dropped or repeated
// reset clears the valid bits and the config registers; tables are constant logic
module easing_curve_evaluator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] time_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] eased_value
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ece_pkg::*;

   logic [2:0] curve_kind_ff, curve_kind_in;
   logic [1:0] ease_dir_ff, ease_dir_in;
   logic       csr_wr;

   // config port, register index is paddr bit 2
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      curve_kind_in = curve_kind_ff;
      ease_dir_in   = ease_dir_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_CURVE_KIND: curve_kind_in = csr_pwdata[2:0];
            default:        ease_dir_in   = csr_pwdata[1:0];
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_CURVE_KIND: csr_prdata = {29'b0, curve_kind_ff};
         default:        csr_prdata = {30'b0, ease_dir_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_kind_ff <= KIND_LINEAR;
         ease_dir_ff   <= DIR_IN;
      end else begin
         curve_kind_ff <= curve_kind_in;
         ease_dir_ff   <= ease_dir_in;
      end
   end

   // pipeline advance: the whole pipe moves unless the output is held
   logic       adv;
   logic [5:0] vld_ff;
   stage_type  s1_in, s2_in, s3_in, s4_in, s5_in;
   stage_type  s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   logic [15:0] out_in, out_ff;

   assign adv        = ~vld_ff[5] | rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[5];
   assign rsp_tdata  = out_ff;

   ece_prep u_prep (
      .time_in (req_tdata),
      .kind    (curve_kind_ff),
      .dir     (ease_dir_ff),
      .st      (s1_in)
   );

   // stage 2: table read, first power step
   always_comb begin
      s2_in = s1_ff;
      if (s1_ff.idx[8]) begin
         s2_in.a = (s1_ff.kind == KIND_EXPO) ? EXP_TAB[TAB_N] : SIN_TAB[TAB_N];
         s2_in.b = s2_in.a;
      end else if (s1_ff.kind == KIND_EXPO) begin
         s2_in.a = EXP_TAB[s1_ff.idx];
         s2_in.b = EXP_TAB[s1_ff.idx + 9'd1];
      end else begin
         s2_in.a = SIN_TAB[s1_ff.idx];
         s2_in.b = SIN_TAB[s1_ff.idx + 9'd1];
      end
      if (s1_ff.steps > 3'd0) s2_in.p = pow_step(s1_ff.p, s1_ff.x);
   end

   // stage 3: interpolation multiply, second power step
   always_comb begin
      s3_in      = s2_ff;
      s3_in.up   = s2_ff.b >= s2_ff.a;
      s3_in.prod = 46'(s3_in.up ? s2_ff.b - s2_ff.a : s2_ff.a - s2_ff.b) * 46'(s2_ff.frac)
                   + 46'(T_HALF);
      if (s2_ff.steps > 3'd1) s3_in.p = pow_step(s2_ff.p, s2_ff.x);
   end

   // stage 4: interpolated value, third power step
   always_comb begin
      s4_in    = s3_ff;
      s4_in.lk = s3_ff.up ? s3_ff.a + s3_ff.prod[45:15] : s3_ff.a - s3_ff.prod[45:15];
      if (s3_ff.steps > 3'd2) s4_in.p = pow_step(s3_ff.p, s3_ff.x);
   end

   // stage 5: exponent shift with rounding, fourth power step
   always_comb begin
      s5_in = s4_ff;
      if (s4_ff.k != 4'd0)
         s5_in.lk = (s4_ff.lk + (31'd1 << (s4_ff.k - 4'd1))) >> s4_ff.k;
      if (s4_ff.steps > 3'd3) s5_in.p = pow_step(s4_ff.p, s4_ff.x);
   end

   // stage 6: combine in Q31 and round once to Q1.15
   logic [Q_W-1:0] q, pq, lq, qr;
   localparam logic [Q_W-1:0] Q_ONE = Q_W'(I_ONE);
   localparam logic [Q_W-1:0] Q_TWO = Q_W'(I_ONE) << 1;

   always_comb begin
      pq = Q_W'(s5_ff.p);
      lq = Q_W'(s5_ff.lk);
      case (s5_ff.kind)
         KIND_SINE: begin
            case (s5_ff.dir)
               DIR_IN:  q = sub0(Q_ONE, lq) << 1;
               DIR_OUT: q = lq << 1;
               default: q = s5_ff.lo ? sub0(Q_ONE, lq) : Q_ONE + lq;
            endcase
         end
         KIND_EXPO: begin
            if (s5_ff.t_zero) q = '0;
            else if (s5_ff.t_one) q = Q_TWO;
            else begin
               case (s5_ff.dir)
                  DIR_IN:  q = lq << 1;
                  DIR_OUT: q = sub0(Q_ONE, lq) << 1;
                  default: q = s5_ff.lo ? lq : sub0(Q_TWO, lq);
               endcase
            end
         end
         default: begin
            if (s5_ff.steps == 3'd0) q = Q_W'(s5_ff.ts) << 16;
            else begin
               case (s5_ff.dir)
                  DIR_IN:  q = pq << 1;
                  DIR_OUT: q = sub0(Q_TWO, pq << 1);
                  default: q = s5_ff.lo ? pq << (s5_ff.steps + 3'd1)
                                        : sub0(Q_TWO, pq << (s5_ff.steps + 3'd1));
               endcase
            end
         end
      endcase
      qr     = q + Q_W'(32768);
      out_in = qr[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[4:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         out_ff <= out_in;
      end
   end

endmodule

[src/ece_prep.sv]
// input conditioning: saturation, direction folding and operand selection
module ece_prep (
   input  logic [15:0]        time_in,
   input  logic [2:0]         kind,
   input  logic [1:0]         dir,
   output ece_pkg::stage_type st
);
   import ece_pkg::*;

   logic [15:0] ts, onem, ph;
   logic [16:0] two;
   logic [1:0]  dirn;
   logic        lo;
   logic [19:0] e10;
   logic [15:0] tp;

   always_comb begin
      ts   = (time_in > T_ONE) ? T_ONE : time_in;
      onem = T_ONE - ts;
      two  = {ts, 1'b0};
      lo   = ts < T_HALF;
      dirn = (dir == DIR_SPARE) ? DIR_INOUT : dir;

      case (dirn)
         DIR_IN:  ph = onem;
         DIR_OUT: ph = ts;
         default: ph = lo ? 16'(17'(T_ONE) - two) : 16'(two - 17'(T_ONE));
      endcase

      // 10*y as shift-add
      e10 = {1'b0, ph, 3'b0} + {3'b0, ph, 1'b0};
      tp  = (kind == KIND_EXPO) ? {1'b0, e10[14:0]} : ph;

      st        = '0;
      st.kind   = kind;
      st.dir    = dirn;
      st.lo     = lo;
      st.t_zero = ts == '0;
      st.t_one  = ts == T_ONE;
      st.ts     = ts;
      case (dirn)
         DIR_IN:  st.x = ts;
         DIR_OUT: st.x = onem;
         default: st.x = lo ? ts : onem;
      endcase
      st.p     = {st.x, 15'b0};
      st.steps = (kind >= KIND_QUAD && kind <= KIND_QUINT) ? kind : 3'd0;
      st.idx   = tp[15:7];
      st.frac  = {tp[6:0], 8'b0};
      st.k     = (kind == KIND_EXPO) ? e10[18:15] : 4'd0;
   end

endmodule

[src/ece_checker.sv]
// port-level checks for the easing curve evaluator, bound to the top level
module ece_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // results never exceed 1.0
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= 16'd32768)
      else $error("eased value above one");

   // input side is ready exactly when the output register can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output stall");

   // nothing is offered right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind easing_curve_evaluator_top ece_checker u_ece_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[verif/easing_curve_evaluator_top_tb.sv]
// self-checking testbench for the easing curve evaluator: directed and random curve points
module easing_curve_evaluator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ece_pkg::*;

   localparam int  LATENCY     = 6;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  RANDOM_PTS  = 1016;
   localparam logic [2:0] ADDR_KIND = 3'd0;
   localparam logic [2:0] ADDR_DIR  = 3'd4;
   localparam logic [2:0] ADDR_NONE = 3'd7;

   // curve point scoreboard: own copy of the registers, predicts eased values in order
   class ease_scoreboard;
      bit [2:0]        kind;
      bit [1:0]        dir;
      bit [15:0]       eased_q[$];
      longint unsigned sin_t[0:TAB_N];
      longint unsigned exp_t[0:TAB_N];
      int              mismatches;

      function new();
         longint unsigned x, x2, z, term, sum;
         kind = 0;
         dir = 0;
         mismatches = 0;
         for (int i = 0; i <= TAB_N; i++) begin
            x = (longint'(i) * 64'd1686629713 + TAB_N / 2) >> TABLE_ADDR_BITS;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int k = 1; k <= 7; k++) begin
               term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
               if (k % 2) sum = (sum > term) ? sum - term : 0;
               else sum += term;
            end
            if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
            if (i == 0) sum = 0;
            if (i == TAB_N) sum = 64'd1 << 30;
            if (i > 0 && sum < sin_t[i-1]) sum = sin_t[i-1];
            sin_t[i] = sum;
         end
         for (int i = 0; i <= TAB_N; i++) begin
            z = (longint'(i) * 64'd744261118 + TAB_N / 2) >> TABLE_ADDR_BITS;
            term = 64'd1 << 30;
            sum = term;
            for (int k = 1; k <= 12; k++) begin
               term = ((term * z) >> 30) / longint'(k);
               if (k % 2) sum = (sum > term) ? sum - term : 0;
               else sum += term;
            end
            if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
            if (i == 0) sum = 64'd1 << 30;
            if (i == TAB_N) sum = 64'd1 << 29;
            if (i > 0 && sum > exp_t[i-1]) sum = exp_t[i-1];
            exp_t[i] = sum;
         end
      endfunction

      function longint unsigned interp(bit use_sin, longint unsigned ph);
         longint unsigned p, idx, f, a, b;
         p = ph << TABLE_ADDR_BITS;
         idx = p >> 15;
         f = p & 64'h7fff;
         if (idx >= TAB_N) return use_sin ? sin_t[TAB_N] : exp_t[TAB_N];
         a = use_sin ? sin_t[idx] : exp_t[idx];
         b = use_sin ? sin_t[idx+1] : exp_t[idx+1];
         if (b >= a) return a + (((b - a) * f + 16384) >> 15);
         return a - (((a - b) * f + 16384) >> 15);
      endfunction

      function longint unsigned decay(longint unsigned y);
         longint unsigned e, sh, v;
         e = 10 * y;
         sh = e >> 15;
         v = interp(0, e & 64'h7fff);
         if (sh > 0 && sh < 63) v = (v + (64'd1 << (sh - 1))) >> sh;
         return v;
      endfunction

      function longint unsigned powq(longint unsigned x, int n);
         longint unsigned p;
         p = x << 15;
         for (int i = 1; i < n; i++) p = (p * x + 16384) >> 15;
         return p;
      endfunction

      function longint unsigned floor0(longint unsigned a, longint unsigned b);
         return (a > b) ? a - b : 0;
      endfunction

      function bit [15:0] eased(bit [15:0] t_raw);
         longint unsigned t, one, v;
         int n;
         bit [1:0] d;
         one = 64'd1 << 30;
         t = (t_raw > 16'h8000) ? 64'h8000 : t_raw;
         d = (dir == DIR_SPARE) ? DIR_INOUT : dir;
         n = kind + 1;
         if (kind >= KIND_QUAD && kind <= KIND_QUINT) begin
            if (d == DIR_IN) v = powq(t, n) << 1;
            else if (d == DIR_OUT) v = floor0(2 * one, powq(32768 - t, n) << 1);
            else if (t < 16384) v = powq(t, n) << n;
            else v = floor0(2 * one, powq(32768 - t, n) << n);
         end else if (kind == KIND_SINE) begin
            if (d == DIR_IN) v = floor0(one, interp(1, 32768 - t)) << 1;
            else if (d == DIR_OUT) v = interp(1, t) << 1;
            else if (t < 16384) v = floor0(one, interp(1, 32768 - 2 * t));
            else v = one + interp(1, 2 * t - 32768);
         end else if (kind == KIND_EXPO) begin
            if (t == 0) v = 0;
            else if (t == 32768) v = 2 * one;
            else if (d == DIR_IN) v = decay(32768 - t) << 1;
            else if (d == DIR_OUT) v = floor0(one, decay(t)) << 1;
            else if (t < 16384) v = decay(32768 - 2 * t);
            else v = floor0(2 * one, decay(2 * t - 32768));
         end else begin
            v = t << 16;
         end
         v = (v + (64'd1 << 15)) >> 16;
         return v[15:0];
      endfunction

      function void note_time(bit [15:0] t);
         eased_q.push_back(eased(t));
      endfunction

      function void check_eased(bit [15:0] got);
         bit [15:0] want;
         if (eased_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result eased_value=%0d", got);
            return;
         end
         want = eased_q.pop_front();
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("eased_value mismatch: expected %0d actual %0d", want, got);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] time_in
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;        // [15:0] eased_value
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ease_scoreboard sb = new();
   int  cycles = 0;
   bit  sink_stalls = 1;   // cleared for stretches with no receiver idling

   easing_curve_evaluator_top u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog over the whole run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: random stall draw per result, check on every accepted transaction
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_eased(rsp_tdata);
         if (!rsp_tready || (rsp_tvalid && rsp_tready)) begin
            gap = sink_stalls ? $urandom_range(0, 11) : 0;
            if (gap == 0) begin
               rsp_tready <= 1;
            end else begin
               rsp_tready <= 0;
               repeat (gap) @(posedge clock);
               rsp_tready <= 1;
            end
         end
      end
   end

   // apb write: setup then access; the model copy follows the register decode
   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      if (addr[2] == 1'b0) sb.kind = data[2:0];
      else sb.dir = data[1:0];
      @(posedge clock);
   endtask

   // send one time sample, with a random idle gap ahead of it when asked
   task automatic send_time(logic [15:0] t, bit idle);
      int gap;
      gap = idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= t;
      do @(posedge clock); while (!req_tready);
      sb.note_time(t);
   endtask

   // stop sending, wait for every expected result, then let the pipe settle
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.eased_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // random time: mostly in range, some saturating, occasional end points
   function automatic logic [15:0] pick_time();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 16'h8000;
      if (sel == 1) return 16'($urandom_range(32769, 65535));
      if (sel == 2) return 16'($urandom_range(0, 3));
      return 16'($urandom_range(0, 32768));
   endfunction

   initial begin
      logic [15:0] directed [$];
      int kinds_left;
      directed = '{16'h0000, 16'h0001, 16'h3fff, 16'h4000, 16'h4001, 16'h7fff,
                   16'h8000, 16'h8001, 16'hffff, 16'h5555, 16'h2aaa, 16'h7ffe};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every curve and direction code, spare codes included
      for (int k = 0; k < 8; k++) begin
         csr_write(ADDR_KIND, 32'hffff_fff8 | k);
         for (int d = 0; d < 4; d++) begin
            if (k == 0 && d == 0) csr_write(ADDR_NONE, 32'hffff_ffff);
            csr_write(ADDR_DIR, 32'hffff_fffc | d);
            foreach (directed[i]) send_time(directed[i], 0);
            drain();
         end
      end

      // random phases: each draws a setting, some run without any idling
      kinds_left = RANDOM_PTS;
      while (kinds_left > 0) begin
         bit quiet;
         quiet = ($urandom_range(0, 3) == 0);
         sink_stalls = !quiet;
         csr_write(ADDR_KIND, $urandom_range(0, 6) | ($urandom & 32'hfffffff8));
         csr_write(ADDR_DIR, $urandom_range(0, 3) | ($urandom & 32'hfffffffc));
         for (int i = 0; i < 70 && kinds_left > 0; i++) begin
            send_time(pick_time(), !quiet);
            kinds_left--;
         end
         drain();
      end
      sink_stalls = 1;

      drain();
      if (sb.mismatches == 0 && sb.eased_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

[filelist.f]
src/ece_pkg.sv
src/ece_prep.sv
src/easing_curve_evaluator_top.sv
src/ece_checker.sv
verif/easing_curve_evaluator_top_tb.sv
